[design/xor_checked_packet_framer_assert.svh]
// Assertion macros used by the framer RTL (xcpf_back).
`ifndef XOR_CHECKED_PACKET_FRAMER_ASSERT_SVH
`define XOR_CHECKED_PACKET_FRAMER_ASSERT_SVH

// Same-cycle implication, checked on clk, off during reset.
`define XCPF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define XCPF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/xcpf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package xcpf_pkg;

	localparam int PADDR_W = 4;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_PREFIX  = 2'd0;
	localparam logic [1:0] REG_SUFFIX  = 2'd1;
	localparam logic [1:0] REG_MAX_LEN = 2'd2;

	localparam logic [15:0] MAX_FRAME_RESET = 16'd128;
	localparam logic [16:0] FRAME_OVERHEAD  = 17'd5;

	// output steps of one job, emitted lowest bit first
	localparam int NUM_STEPS   = 7;
	localparam int STEP_PREFIX = 0;
	localparam int STEP_LEN_HI = 1;
	localparam int STEP_LEN_LO = 2;
	localparam int STEP_DATA   = 3;
	localparam int STEP_CHK    = 4;
	localparam int STEP_SUFFIX = 5;
	localparam int STEP_ERR    = 6;

	typedef logic [NUM_STEPS-1:0] steps_t;

	typedef struct packed {
		logic [7:0]  prefix_byte;
		logic [7:0]  suffix_byte;
		logic [15:0] max_frame_len;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [15:0] payload_length;
		logic        last_byte;
		logic        no_payload;
	} in_item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       size_error;
		logic       run_end;
	} out_item_t;

	typedef struct packed {
		steps_t      steps;
		logic [7:0]  data;
		logic [15:0] len;
		logic [7:0]  csum;
	} job_t;

	typedef struct packed {
		logic push;
		job_t job;
	} push_t;

	typedef struct packed {
		logic full;
		logic empty;
		job_t head;
	} q_status_t;

endpackage

`default_nettype wire

[design/xor_checked_packet_framer.sv]
// Length-prefixed frame builder with XOR checksum.
// Payload channel (payload_valid/payload_stall/payload) takes one byte per item;
// a packet's first item also supplies payload_length. Frame channel
// (frame_valid/frame_stall/frame) gives one frame byte per item, run_end marking
// the last byte caused by one payload item.
// A first item yields prefix, length high, length low and the data byte (4 bytes),
// a middle item 1, a last item data, checksum and suffix (3), a single-byte
// packet 6, an empty request 5 between packets or 2 inside one, an oversize
// packet one error item.
// Throughput is one frame byte per cycle while frame_stall is low, set by the
// output sequencer; payload items are taken every cycle while the job queue
// (QUEUE_DEPTH entries) has room, and pass the queue, step and output registers.
// When the receiver stalls, the output register holds and the queue fills;
// payload_stall rises once the queue is full.
// Reset clears the packet state, the queue and the output; registers return to
// prefix 0, suffix 0, max_frame_len 128. Registers sit at 0x0, 0x4, 0x8.
`timescale 1ns / 1ps
`default_nettype none

module xor_checked_packet_framer import xcpf_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               payload_valid,
	output logic               payload_stall,
	input  in_item_t           payload,
	output logic               frame_valid,
	input  logic               frame_stall,
	output out_item_t          frame
);

	cfg_t      cfg;
	push_t     wr;
	q_status_t q;
	logic      pop;

	assign payload_stall = q.full;

	xcpf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	xcpf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.payload_valid (payload_valid),
		.payload       (payload),
		.q_full        (q.full),
		.wr            (wr)
	);

	xcpf_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.pop    (pop),
		.status (q)
	);

	xcpf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.q           (q),
		.pop         (pop),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame       (frame)
	);

endmodule

`default_nettype wire

[design/xcpf_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module xcpf_regs import xcpf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prefix_byte   <= 8'd0;
			cfg_q.suffix_byte   <= 8'd0;
			cfg_q.max_frame_len <= MAX_FRAME_RESET;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_PREFIX:  cfg_q.prefix_byte   <= pwdata[7:0];
				REG_SUFFIX:  cfg_q.suffix_byte   <= pwdata[7:0];
				REG_MAX_LEN: cfg_q.max_frame_len <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_PREFIX:  prdata = {24'd0, cfg_q.prefix_byte};
			REG_SUFFIX:  prdata = {24'd0, cfg_q.suffix_byte};
			REG_MAX_LEN: prdata = {16'd0, cfg_q.max_frame_len};
			default:     prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

[design/xcpf_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module xcpf_front import xcpf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     payload_valid,
	input  in_item_t payload,
	input  logic     q_full,
	output push_t    wr
);

	logic       inside_q;
	logic       drop_q;
	logic [7:0] xor_q;

	logic        accept;
	logic        ends;
	logic [15:0] len_eff;
	logic        oversize;
	logic [7:0]  xor_nxt;
	job_t        job;
	logic        inside_nxt;
	logic        drop_nxt;
	logic [7:0]  xor_upd;

	assign accept   = payload_valid && !q_full;
	assign ends     = payload.last_byte || payload.no_payload;
	assign len_eff  = payload.no_payload ? 16'd0 : payload.payload_length;
	// 17-bit compare, length + overhead cannot wrap
	assign oversize = {1'b0, cfg.max_frame_len} < ({1'b0, len_eff} + FRAME_OVERHEAD);

	always_comb begin
		job        = '0;
		job.data   = payload.data_byte;
		job.len    = len_eff;
		inside_nxt = inside_q;
		drop_nxt   = drop_q;
		xor_upd    = xor_q;
		xor_nxt    = '0;
		priority if (drop_q) begin
			if (ends) begin
				drop_nxt   = 1'b0;
				inside_nxt = 1'b0;
			end
		end else if (!inside_q && oversize) begin
			job.steps[STEP_ERR] = 1'b1;
			if (!ends) begin
				drop_nxt   = 1'b1;
				inside_nxt = 1'b1;
			end
		end else begin
			// running checksum restarts on a packet's first item
			xor_nxt = inside_q ? xor_q : 8'd0;
			if (!inside_q) begin
				job.steps[STEP_PREFIX] = 1'b1;
				job.steps[STEP_LEN_HI] = 1'b1;
				job.steps[STEP_LEN_LO] = 1'b1;
			end
			if (!payload.no_payload) begin
				job.steps[STEP_DATA] = 1'b1;
				xor_nxt = xor_nxt ^ payload.data_byte;
			end
			job.csum = xor_nxt;
			if (ends) begin
				job.steps[STEP_CHK]    = 1'b1;
				job.steps[STEP_SUFFIX] = 1'b1;
				inside_nxt = 1'b0;
				xor_upd    = 8'd0;
			end else begin
				inside_nxt = 1'b1;
				xor_upd    = xor_nxt;
			end
		end
	end

	assign wr.push = accept && (job.steps != '0);
	assign wr.job  = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			drop_q   <= 1'b0;
			xor_q    <= 8'd0;
		end else if (accept) begin
			inside_q <= inside_nxt;
			drop_q   <= drop_nxt;
			xor_q    <= xor_upd;
		end
	end

endmodule

`default_nettype wire

[design/xcpf_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module xcpf_fifo import xcpf_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  push_t     wr,
	input  logic      pop,
	output q_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign status.full  = (count_q == FULL_CNT);
	assign status.empty = (count_q == '0);
	assign status.head  = mem_q[rd_ptr_q];

	assign do_push = wr.push && !status.full;
	assign do_pop  = pop && !status.empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[design/xcpf_back.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "xor_checked_packet_framer_assert.svh"

module xcpf_back import xcpf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  q_status_t q,
	output logic      pop,
	output logic      frame_valid,
	input  logic      frame_stall,
	output out_item_t frame
);

	steps_t     steps_q;
	job_t       job_q;
	logic       out_valid_q;
	out_item_t  out_q;

	steps_t     sel;
	steps_t     rest;
	logic [7:0] byte_val;
	logic       adv;

	// pick the lowest pending step
	always_comb begin
		sel      = '0;
		byte_val = 8'd0;
		priority if (steps_q[STEP_PREFIX]) begin
			sel[STEP_PREFIX] = 1'b1;
			byte_val         = cfg.prefix_byte;
		end else if (steps_q[STEP_LEN_HI]) begin
			sel[STEP_LEN_HI] = 1'b1;
			byte_val         = job_q.len[15:8];
		end else if (steps_q[STEP_LEN_LO]) begin
			sel[STEP_LEN_LO] = 1'b1;
			byte_val         = job_q.len[7:0];
		end else if (steps_q[STEP_DATA]) begin
			sel[STEP_DATA] = 1'b1;
			byte_val       = job_q.data;
		end else if (steps_q[STEP_CHK]) begin
			sel[STEP_CHK] = 1'b1;
			byte_val      = job_q.csum;
		end else if (steps_q[STEP_SUFFIX]) begin
			sel[STEP_SUFFIX] = 1'b1;
			byte_val         = cfg.suffix_byte;
		end else if (steps_q[STEP_ERR]) begin
			sel[STEP_ERR] = 1'b1;
		end
	end

	assign adv  = (steps_q != '0) && (!out_valid_q || !frame_stall);
	assign rest = steps_q & ~sel;
	// reload as the last step goes out, so unstalled one-byte jobs run every cycle
	assign pop  = !q.empty && ((steps_q == '0) || (adv && (rest == '0)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
		end else if (pop) begin
			steps_q <= q.head.steps;
		end else if (adv) begin
			steps_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q.head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!frame_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.frame_byte <= byte_val;
			out_q.size_error <= sel[STEP_ERR];
			out_q.run_end    <= (rest == '0);
		end
	end

	assign frame_valid = out_valid_q;
	assign frame       = out_q;

	`XCPF_ASSERT_NOW(a_sel_onehot, adv, $onehot(sel), "step select not one-hot")
	`XCPF_ASSERT_NOW(a_err_alone, steps_q[STEP_ERR], steps_q == sel, "error step mixed with bytes")
	`XCPF_ASSERT_NOW(a_err_ends, out_valid_q && out_q.size_error, out_q.run_end,
		"error result not last of its item")
	`XCPF_ASSERT_NEXT(a_idle_loads, (steps_q == '0) && !q.empty, steps_q != '0,
		"back end idle with a job queued")

endmodule

`default_nettype wire

[tb/xcpf_frame_checker.sv]
`timescale 1ns / 1ps

module xcpf_frame_checker import xcpf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	input  logic               payload_valid,
	input  logic               payload_stall,
	input  in_item_t           payload,
	input  logic               frame_valid,
	input  logic               frame_stall,
	input  out_item_t          frame,
	output int                 errors,
	output int                 pending
);

	logic [7:0]  prefix_val;
	logic [7:0]  suffix_val;
	logic [15:0] max_len;
	logic        in_packet;
	logic        dropping;
	logic [7:0]  xor_sum;
	out_item_t   due_bytes[$];

	function automatic out_item_t frame_out(input logic [7:0] b, input logic err);
		out_item_t o;
		o.frame_byte = b;
		o.size_error = err;
		o.run_end    = 1'b0;
		return o;
	endfunction

	// frame bytes caused by one payload item, appended to due_bytes
	function automatic void predict_frame_bytes(input in_item_t it);
		out_item_t   run[$];
		logic [15:0] len;
		logic [16:0] need;
		logic        open_pkt;
		open_pkt = 1'b0;
		if (dropping) begin
			// swallowing an oversize packet until its end
			if (it.last_byte || it.no_payload) begin
				dropping  = 1'b0;
				in_packet = 1'b0;
			end
		end else begin
			open_pkt = 1'b1;
			if (!in_packet) begin
				len  = it.no_payload ? 16'd0 : it.payload_length;
				need = {1'b0, len} + FRAME_OVERHEAD;
				if ({1'b0, max_len} < need) begin
					run.push_back(frame_out(8'h00, 1'b1));
					if (!(it.last_byte || it.no_payload)) begin
						dropping  = 1'b1;
						in_packet = 1'b1;
					end
					open_pkt = 1'b0;
				end else begin
					run.push_back(frame_out(prefix_val, 1'b0));
					run.push_back(frame_out(len[15:8], 1'b0));
					run.push_back(frame_out(len[7:0], 1'b0));
					xor_sum = 8'h00;
					if (it.no_payload) begin
						run.push_back(frame_out(8'h00, 1'b0));
						run.push_back(frame_out(suffix_val, 1'b0));
						open_pkt = 1'b0;
					end else begin
						in_packet = 1'b1;
					end
				end
			end
			if (open_pkt) begin
				if (!it.no_payload) begin
					run.push_back(frame_out(it.data_byte, 1'b0));
					xor_sum = xor_sum ^ it.data_byte;
				end
				if (it.last_byte || it.no_payload) begin
					run.push_back(frame_out(xor_sum, 1'b0));
					run.push_back(frame_out(suffix_val, 1'b0));
					in_packet = 1'b0;
					xor_sum   = 8'h00;
				end
			end
		end
		if (run.size() != 0)
			run[run.size() - 1].run_end = 1'b1;
		foreach (run[i])
			due_bytes.push_back(run[i]);
	endfunction

	// sampled mid-cycle: inputs and outputs only move on the rising edge, so what is
	// seen here is what the next rising edge takes
	always @(negedge clk) begin
		out_item_t want;
		if (!arst_n) begin
			prefix_val = 8'h00;
			suffix_val = 8'h00;
			max_len    = MAX_FRAME_RESET;
			in_packet  = 1'b0;
			dropping   = 1'b0;
			xor_sum    = 8'h00;
			errors     = 0;
			due_bytes.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_PREFIX:  prefix_val = pwdata[7:0];
					REG_SUFFIX:  suffix_val = pwdata[7:0];
					REG_MAX_LEN: max_len = pwdata[15:0];
					default: ;
				endcase
			end
			if (payload_valid && !payload_stall)
				predict_frame_bytes(payload);
			if (frame_valid && !frame_stall) begin
				if (due_bytes.size() == 0) begin
					errors++;
					$display("%0t: unexpected frame item: expected none, got %h err %b end %b",
						$time, frame.frame_byte, frame.size_error, frame.run_end);
				end else begin
					want = due_bytes.pop_front();
					if (frame.frame_byte !== want.frame_byte
						|| frame.size_error !== want.size_error
						|| frame.run_end !== want.run_end) begin
						errors++;
						$display("%0t: frame mismatch: expected %h err %b end %b, got %h err %b end %b",
							$time, want.frame_byte, want.size_error, want.run_end,
							frame.frame_byte, frame.size_error, frame.run_end);
					end
				end
			end
		end
		pending = due_bytes.size();
	end

endmodule

[tb/tb_xor_checked_packet_framer.sv]
`timescale 1ns / 1ps

module tb_xor_checked_packet_framer;
	import xcpf_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 330;
	localparam int PHASE_ITEMS  = 40;
	localparam int SETTLE       = 12;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               payload_valid;
	logic               payload_stall;
	in_item_t           payload;
	logic               frame_valid;
	logic               frame_stall;
	out_item_t          frame;

	int errors;
	int pending;
	int items_sent;
	int gap_rate;
	bit calm;

	xor_checked_packet_framer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.payload_valid (payload_valid),
		.payload_stall (payload_stall),
		.payload       (payload),
		.frame_valid   (frame_valid),
		.frame_stall   (frame_stall),
		.frame         (frame)
	);

	xcpf_frame_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.payload_valid (payload_valid),
		.payload_stall (payload_stall),
		.payload       (payload),
		.frame_valid   (frame_valid),
		.frame_stall   (frame_stall),
		.frame         (frame),
		.errors        (errors),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	// receiver stalls in bursts; the rate is redrawn now and then, rate 0 means none
	initial begin
		int left;
		int rate;
		frame_stall <= 1'b0;
		left = 0;
		rate = 0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				left = 40;
				rate = $urandom_range(0, 3);
			end
			left--;
			if (!calm && rate != 0 && $urandom_range(0, 7) < rate) begin
				frame_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				frame_stall <= 1'b0;
			end
		end
	end

	function automatic in_item_t mk_item(input logic [7:0] d, input logic [15:0] len,
		input logic last, input logic empty);
		in_item_t it;
		it.data_byte      = d;
		it.payload_length = len;
		it.last_byte      = last;
		it.no_payload     = empty;
		return it;
	endfunction

	task automatic send_item(input in_item_t it);
		int gap;
		bit taken;
		gap = 0;
		if (!calm && gap_rate != 0 && $urandom_range(0, 9) < gap_rate)
			gap = $urandom_range(1, 5);
		if (gap != 0) begin
			payload_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		payload       <= it;
		payload_valid <= 1'b1;
		do begin
			@(negedge clk);
			taken = !payload_stall;
			@(posedge clk);
		end while (!taken);
		items_sent++;
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		bit done;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			done = pready;
			@(posedge clk);
		end while (!done);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// registers change only once the framer has drained
	task automatic set_config(input logic [7:0] pre, input logic [7:0] suf,
		input logic [15:0] max_frame);
		payload_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		reg_write(REG_PREFIX, {24'd0, pre});
		reg_write(REG_SUFFIX, {24'd0, suf});
		reg_write(REG_MAX_LEN, {16'd0, max_frame});
	endtask

	task automatic send_random_packet();
		int kind;
		int n;
		logic [15:0] decl;
		kind     = $urandom_range(0, 99);
		gap_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
		n        = $urandom_range(1, 10);
		if (kind < 10) begin
			send_item(mk_item(8'($urandom), 16'($urandom), 1'($urandom), 1'b1));
		end else if (kind < 15) begin
			send_item(in_item_t'($urandom));
		end else begin
			if (kind < 55)
				decl = 16'(n);
			else if (kind < 75)
				decl = 16'($urandom_range(0, 255));
			else
				decl = 16'($urandom);
			// kind 15..24: packet closed by an empty request instead of a last byte
			for (int i = 0; i < n; i++)
				send_item(mk_item(8'($urandom), (i == 0) ? decl : 16'($urandom),
					i == n - 1 && kind >= 25, 1'b0));
			if (kind < 25)
				send_item(mk_item(8'($urandom), 16'($urandom), 1'($urandom), 1'b1));
		end
	endtask

	initial begin
		int base;
		int phase_start;
		int r;
		logic [15:0] max_frame;
		arst_n        <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		payload_valid <= 1'b0;
		payload       <= '0;
		calm       = 1'b0;
		items_sent = 0;
		gap_rate   = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(8'hA5, 8'h5A, MAX_FRAME_RESET);
		// empty frame, length field ignored
		send_item(mk_item(8'hFF, 16'hFFFF, 1'b1, 1'b1));
		// single-byte packet
		send_item(mk_item(8'hFF, 16'h0001, 1'b1, 1'b0));
		send_item(mk_item(8'h00, 16'h0003, 1'b0, 1'b0));
		send_item(mk_item(8'hFF, 16'h0000, 1'b0, 1'b0));
		send_item(mk_item(8'h3C, 16'h0000, 1'b1, 1'b0));
		// one byte too long: error, then the rest swallowed
		send_item(mk_item(8'h11, 16'd124, 1'b0, 1'b0));
		send_item(mk_item(8'h22, 16'h0000, 1'b0, 1'b0));
		send_item(mk_item(8'h33, 16'h0000, 1'b1, 1'b0));
		send_item(mk_item(8'h44, 16'hFFFF, 1'b1, 1'b0));
		// exact fit
		send_item(mk_item(8'h80, 16'd123, 1'b1, 1'b0));
		// empty request closes an open packet
		send_item(mk_item(8'h01, 16'h0002, 1'b0, 1'b0));
		send_item(mk_item(8'h02, 16'h0000, 1'b0, 1'b1));
		// drop ended by an empty request
		send_item(mk_item(8'h00, 16'h8000, 1'b0, 1'b0));
		send_item(mk_item(8'h55, 16'h0000, 1'b0, 1'b1));

		set_config(8'hFF, 8'h00, 16'd0);
		send_item(mk_item(8'h12, 16'h0000, 1'b0, 1'b1));
		send_item(mk_item(8'h34, 16'h0000, 1'b1, 1'b0));
		set_config(8'hFF, 8'h00, 16'd4);
		send_item(mk_item(8'h56, 16'h0000, 1'b1, 1'b1));
		set_config(8'h00, 8'hFF, 16'd5);
		send_item(mk_item(8'h78, 16'h1234, 1'b0, 1'b1));
		send_item(mk_item(8'h9A, 16'h0000, 1'b1, 1'b0));
		set_config(8'h00, 8'hFF, 16'hFFFF);
		// 65530 fits in 65535, 65531 does not
		send_item(mk_item(8'hBC, 16'hFFFA, 1'b1, 1'b0));
		send_item(mk_item(8'hDE, 16'hFFFB, 1'b1, 1'b0));

		base = items_sent;
		while (items_sent - base < RANDOM_ITEMS) begin
			r = $urandom_range(0, 4);
			case (r)
				0: max_frame = 16'hFFFF;
				1: max_frame = MAX_FRAME_RESET;
				2: max_frame = 16'($urandom_range(5, 40));
				3: max_frame = 16'($urandom);
				default: max_frame = 16'($urandom_range(0, 4));
			endcase
			set_config(8'($urandom), 8'($urandom), max_frame);
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS && items_sent - base < RANDOM_ITEMS) begin
				calm = (items_sent - base) >= RANDOM_ITEMS - PHASE_ITEMS;
				send_random_packet();
			end
			// leave the framer between packets before the next setting
			send_item(mk_item(8'($urandom), 16'($urandom), 1'b1, 1'b0));
		end
		payload_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[filelist.f]
+incdir+design
design/xcpf_pkg.sv
design/xcpf_regs.sv
design/xcpf_front.sv
design/xcpf_fifo.sv
design/xcpf_back.sv
design/xor_checked_packet_framer.sv
tb/xcpf_frame_checker.sv
tb/tb_xor_checked_packet_framer.sv
